@@ rtl/core/lorf_pkg.sv @@
// Shared types and defaults for the longest-ones-run-with-flips core.
// No dependencies; imported by every module of the core.
`default_nettype none

package lorf_pkg;

    localparam int IndexWidthDefault = 16;
    localparam int FlipDepthDefault  = 16;
    localparam int CfgWidth          = 5;
    localparam int InTdataWidth      = 8;

    localparam logic [CfgWidth-1:0] MaxFlipsReset = CfgWidth'(1);

    // One stream element as it travels from front to back.
    typedef struct packed {
        logic bit_value;
        logic last;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/core/lorf_front.sv @@
// Input side: accepts stream transfers and holds them in a two-entry queue.
// Depends on lorf_pkg for item_t.
`default_nettype none

module lorf_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lorf_pkg::InTdataWidth-1:0]  s_axis_tdata,   // [0] bit_value, rest zero
    input  wire logic                               s_axis_tlast,   // last
    output logic                                    q_valid,
    output lorf_pkg::item_t                         q_item,
    input  wire logic                               q_ready
);
    import lorf_pkg::*;

    logic [1:0] count_reg, count_next;
    item_t      ent_reg [2];
    item_t      ent_next [2];
    item_t      in_item;
    logic       push;
    logic       pop;
    logic       wr_idx;

    assign in_item.bit_value = s_axis_tdata[0];
    assign in_item.last      = s_axis_tlast;

    assign s_axis_tready = (count_reg != 2'd2);
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = ent_reg[0];

    assign push   = s_axis_tvalid && s_axis_tready;
    assign pop    = q_valid && q_ready;
    assign wr_idx = 1'(count_reg - {1'b0, pop});

    always_comb begin
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop) begin
            ent_next[0] = ent_reg[1];
        end
        if (push) begin
            ent_next[wr_idx] = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

endmodule

`default_nettype wire

@@ rtl/core/lorf_back.sv @@
// Window engine: zero-position FIFO, window start, best-window tracking and
// the registered result stage. Depends on lorf_pkg.
`default_nettype none

module lorf_back #(
    parameter int INDEX_WIDTH = lorf_pkg::IndexWidthDefault,
    parameter int FLIP_DEPTH  = lorf_pkg::FlipDepthDefault,
    parameter int OUT_TDATA_W = ((2 * INDEX_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [lorf_pkg::CfgWidth-1:0]  max_flips,
    input  wire logic                           q_valid,
    input  wire lorf_pkg::item_t                q_item,
    output logic                                q_ready,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [OUT_TDATA_W-1:0]              m_axis_tdata
);
    import lorf_pkg::*;

    localparam int IW  = INDEX_WIDTH;
    localparam int PW  = (FLIP_DEPTH > 1) ? $clog2(FLIP_DEPTH) : 1;
    localparam int CW  = $clog2(FLIP_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int LW  = (CW > CfgWidth) ? CW : CfgWidth;
    localparam int PAD = OUT_TDATA_W - (2 * IW + 1);

    function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        d = SW'(FLIP_DEPTH);
        return (s >= d) ? PW'(s - d) : PW'(s);
    endfunction

    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] ws_reg, ws_next;
    logic [CW-1:0] zc_reg, zc_next;
    logic [PW-1:0] head_reg, head_next;
    logic [IW-1:0] best_start_reg, best_start_next;
    logic [IW-1:0] best_len_reg, best_len_next;
    logic          flag_reg, flag_next;
    logic [IW-1:0] zp_reg [FLIP_DEPTH];

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic          out_free;
    logic          fire;
    logic [CW-1:0] limit;
    logic [CW-1:0] target;
    logic [CW-1:0] drop;
    logic [PW-1:0] rd_idx;
    logic [CW-1:0] zc_mid;
    logic [PW-1:0] head_mid;
    logic [IW-1:0] win_len;
    logic          zp_wen;
    logic [PW-1:0] zp_widx;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign q_ready  = out_free || !q_item.last;
    assign fire     = q_valid && q_ready;

    assign limit  = (LW'(max_flips) > LW'(FLIP_DEPTH)) ? CW'(FLIP_DEPTH) : CW'(max_flips);
    assign target = q_item.bit_value ? limit : limit - CW'(1);
    assign drop   = zc_reg - target;
    assign rd_idx = wrap(SW'(head_reg) + SW'(drop) - SW'(1));

    always_comb begin
        pos_next        = pos_reg;
        ws_next         = ws_reg;
        zc_next         = zc_reg;
        head_next       = head_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        flag_next       = flag_reg;
        zc_mid          = zc_reg;
        head_mid        = head_reg;
        win_len         = '0;
        zp_wen          = 1'b0;
        zp_widx         = wrap(SW'(head_reg) + SW'(zc_reg));
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (fire) begin
            if (pos_reg == {IW{1'b1}}) begin
                flag_next = 1'b1;
            end else begin
                if (!q_item.bit_value && limit == '0) begin
                    ws_next   = pos_reg + IW'(1);
                    zc_next   = '0;
                    head_next = '0;
                end else begin
                    if (zc_reg > target) begin
                        ws_next  = zp_reg[rd_idx] + IW'(1);
                        head_mid = wrap(SW'(head_reg) + SW'(drop));
                        zc_mid   = target;
                    end
                    head_next = head_mid;
                    zc_next   = zc_mid;
                    if (!q_item.bit_value) begin
                        zp_wen  = 1'b1;
                        zp_widx = wrap(SW'(head_mid) + SW'(zc_mid));
                        zc_next = zc_mid + CW'(1);
                    end
                end
                win_len = pos_reg + IW'(1) - ws_next;
                if (win_len > best_len_reg) begin
                    best_len_next   = win_len;
                    best_start_next = ws_next;
                end
                pos_next = pos_reg + IW'(1);
            end
        end

        if (fire && q_item.last) begin
            m_valid_next    = 1'b1;
            m_data_next     = {{PAD{1'b0}}, flag_next, best_len_next, best_start_next};
            pos_next        = '0;
            ws_next         = '0;
            zc_next         = '0;
            head_next       = '0;
            best_start_next = '0;
            best_len_next   = '0;
            flag_next       = 1'b0;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            ws_reg         <= '0;
            zc_reg         <= '0;
            head_reg       <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            flag_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            ws_reg         <= ws_next;
            zc_reg         <= zc_next;
            head_reg       <= head_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            flag_reg       <= flag_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (zp_wen) begin
            zp_reg[zp_widx] <= pos_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/longest_ones_run_with_flips_core.sv @@
// Top level: max_flips register, front queue and window engine.
// Depends on lorf_pkg, lorf_front and lorf_back.
//
//   channel   dir  tdata (low bit up)                          tuser  tlast
//   s_axis    in   bit_value, zero pad to 8                    -      last
//   m_axis    out  best_start, best_length, overflow, zero pad  -      -
//   cfg       in   cfg_wdata = max_flips (5 bits), cfg_wen     -      -
//
// One element per cycle sustained unless a last element waits on a held result.
// An element passes the queue entry, then the window and result registers in the engine.
// A waiting result does not block elements without tlast; the two-entry queue
// lets input keep flowing while the engine waits on m_axis_tready.
// Reset clears all stream state and sets max_flips to 1; no clearing pass.
`default_nettype none

module longest_ones_run_with_flips_core #(
    parameter int INDEX_WIDTH = lorf_pkg::IndexWidthDefault,
    parameter int FLIP_DEPTH  = lorf_pkg::FlipDepthDefault,
    parameter int OUT_TDATA_W = ((2 * INDEX_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wen,
    input  wire logic [lorf_pkg::CfgWidth-1:0]      cfg_wdata,      // max_flips
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lorf_pkg::InTdataWidth-1:0]  s_axis_tdata,   // [0] bit_value
    input  wire logic                               s_axis_tlast,   // last
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                  m_axis_tdata    // best_start, best_length,
                                                                    // overflow
);
    import lorf_pkg::*;

    logic [CfgWidth-1:0] max_flips_reg, max_flips_next;
    logic                q_valid;
    logic                q_ready;
    item_t               q_item;

    assign max_flips_next = cfg_wen ? cfg_wdata : max_flips_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_flips_reg <= MaxFlipsReset;
        end else begin
            max_flips_reg <= max_flips_next;
        end
    end

    lorf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_ready       (q_ready)
    );

    lorf_back #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .FLIP_DEPTH  (FLIP_DEPTH),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .max_flips     (max_flips_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_ready       (q_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    localparam int IW = INDEX_WIDTH;

    logic [IW-1:0] res_start;
    logic [IW-1:0] res_len;
    logic [IW:0]   res_end;

    assign res_start = m_axis_tdata[IW-1:0];
    assign res_len   = m_axis_tdata[2*IW-1:IW];
    assign res_end   = {1'b0, res_start} + {1'b0, res_len};

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready && q_item.last |=> m_axis_tvalid)
        else $error("last element did not produce a result");

    a_full_means_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> q_valid)
        else $error("input stalled with empty queue");

    a_window_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> res_end <= {1'b0, {IW{1'b1}}})
        else $error("result window extends past index range");

    a_empty_window_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res_len == '0 |-> res_start == '0)
        else $error("empty window with nonzero start");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for longest_ones_run_with_flips_core: directed streams, then random streams
// under four idle/stall patterns; each result matched to a window tracker or table row.
// Depends on lorf_pkg and the RTL of the core.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lorf_pkg::*;

    localparam int IndexW     = IndexWidthDefault;
    localparam int FlipDepth  = FlipDepthDefault;
    localparam int OutW       = ((2 * IndexW + 1 + 7) / 8) * 8;
    localparam int PosLimit   = (1 << IndexW) - 1;
    localparam int HoldCycles = 400;
    localparam int SettleCyc  = 6;

    typedef struct {
        logic [15:0] start;
        logic [15:0] length;
        logic        ovf;
    } window_t;

    typedef struct {
        logic [4:0]  flips;
        int unsigned len;
        logic [31:0] pat;
        logic        fill;
        logic        lst;
        logic        typed;
        logic [15:0] e_start;
        logic [15:0] e_len;
        logic        e_ovf;
    } stim_row_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wen       = 1'b0;
    logic [CfgWidth-1:0]     cfg_wdata     = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [InTdataWidth-1:0] s_axis_tdata  = '0;   // [0] bit_value, rest zero
    logic                    s_axis_tlast  = 1'b0; // last
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OutW-1:0]         m_axis_tdata;         // best_start, best_length, overflow

    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    logic hold_start   = 1'b0;
    int  hold_cnt      = 0;
    int  err_count     = 0;

    window_t pending_wins[$];

    // window tracker state
    logic [4:0]  flips_now;
    int unsigned run_pos;
    int unsigned win_start;
    int unsigned zero_cnt;
    logic [15:0] zero_at [FlipDepth];
    logic [3:0]  zhead;
    logic [15:0] best_st;
    logic [15:0] best_len;
    logic        ovf_seen;

    longest_ones_run_with_flips_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void clear_run();
        run_pos   = 0;
        win_start = 0;
        zero_cnt  = 0;
        zhead     = '0;
        best_st   = '0;
        best_len  = '0;
        ovf_seen  = 1'b0;
    endfunction

    // Advances the window by one element; returns 1 when the element closes a stream.
    function automatic bit window_step(input logic b, input logic l, output window_t w);
        int unsigned lim;
        int unsigned tgt;
        int unsigned drop;
        int unsigned run_len;
        logic [3:0]  idx;
        if (run_pos < PosLimit) begin
            lim = (flips_now > FlipDepth) ? FlipDepth : flips_now;
            if (!b && lim == 0) begin
                win_start = run_pos + 1;
                zero_cnt  = 0;
                zhead     = '0;
            end else begin
                tgt = b ? lim : lim - 1;
                if (zero_cnt > tgt) begin
                    drop      = zero_cnt - tgt;
                    idx       = 4'(zhead + drop - 1);
                    win_start = zero_at[idx] + 1;
                    zhead     = 4'(zhead + drop);
                    zero_cnt  = tgt;
                end
                if (!b) begin
                    zero_at[4'(zhead + zero_cnt)] = 16'(run_pos);
                    zero_cnt++;
                end
            end
            run_len = run_pos + 1 - win_start;
            if (run_len > best_len) begin
                best_len = 16'(run_len);
                best_st  = 16'(win_start);
            end
            run_pos++;
        end else begin
            ovf_seen = 1'b1;
        end
        w.start  = best_st;
        w.length = best_len;
        w.ovf    = ovf_seen;
        if (l) clear_run();
        return l;
    endfunction

    task automatic push_bit(input logic b, input logic l, input bit use_typed,
                            input window_t typed_w);
        window_t w;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InTdataWidth-1){1'b0}}, b};
        s_axis_tlast  <= l;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (window_step(b, l, w))
            pending_wins.insert(pending_wins.size(), use_typed ? typed_w : w);
    endtask

    // Only while idle: drains results and lets in-flight elements settle first.
    task automatic write_flips(input logic [4:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_wins.size() != 0) @(posedge aclk);
        repeat (SettleCyc) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        flips_now = v;
    endtask

    always @(posedge aclk) begin
        if (hold_start && hold_cnt < HoldCycles) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        window_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_wins.size() == 0) begin
                log_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_wins.pop_front();
                if (m_axis_tdata[15:0] !== want.start)
                    log_mismatch($sformatf("best_start got %0d want %0d",
                                           m_axis_tdata[15:0], want.start));
                if (m_axis_tdata[31:16] !== want.length)
                    log_mismatch($sformatf("best_length got %0d want %0d",
                                           m_axis_tdata[31:16], want.length));
                if (m_axis_tdata[32] !== want.ovf)
                    log_mismatch($sformatf("overflow got %0b want %0b",
                                           m_axis_tdata[32], want.ovf));
            end
        end
    end

    initial begin
        stim_row_t rows [14];
        window_t     tw;
        int unsigned i;
        int unsigned stream_left;
        int          one_pct;
        int          k;
        logic        b;
        logic [4:0]  v;
        int          src_tab  [4];
        int          sink_tab [4];

        src_tab  = '{0, 74, 0, 11};
        sink_tab = '{0, 0, 74, 11};

        rows = '{
            '{5'd1,  1,  32'h0000_0001, 1'b0, 1'b1, 1'b1, 16'd0, 16'd1,  1'b0},
            '{5'd1,  1,  32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'd0, 16'd1,  1'b0},
            '{5'd0,  4,  32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0,  1'b0},
            '{5'd0,  8,  32'h0000_00DC, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0,  1'b0},
            '{5'd16, 32, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'd0, 16'd16, 1'b0},
            '{5'd31, 20, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 16'd0, 16'd16, 1'b0},
            '{5'd20, 32, 32'h5555_AAAA, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0,  1'b0},
            '{5'd2,  32, 32'h0F0F_3C3C, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0,  1'b0},
            '{5'd0,  32, 32'hFFF0_0FF1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0,  1'b0},
            '{5'd5,  32, 32'h9249_2492, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0,  1'b0},
            '{5'd1,  20, 32'h0000_FFF7, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0,  1'b0},
            '{5'd16, 40, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'd0, 16'd40, 1'b0},
            '{5'd0,  6,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0,  1'b0},
            '{5'd0,  1,  32'h0000_0001, 1'b0, 1'b1, 1'b1, 16'd6, 16'd1,  1'b0}
        };

        flips_now = MaxFlipsReset;
        for (i = 0; i < FlipDepth; i++) zero_at[i] = '0;
        clear_run();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            if (rows[r].flips != flips_now) write_flips(rows[r].flips);
            tw.start  = rows[r].e_start;
            tw.length = rows[r].e_len;
            tw.ovf    = rows[r].e_ovf;
            for (i = 0; i < rows[r].len; i++) begin
                b = (i < 32) ? rows[r].pat[i] : rows[r].fill;
                push_bit(b, rows[r].lst && (i == rows[r].len - 1), rows[r].typed, tw);
            end
        end

        stream_left = 0;
        one_pct     = 50;
        for (int mode = 0; mode < 4; mode++) begin
            for (int chunk = 0; chunk < 3; chunk++) begin
                k = $urandom_range(9);
                if (k == 0)      v = 5'd0;
                else if (k == 1) v = 5'd16;
                else if (k == 2) v = 5'($urandom_range(31, 17));
                else             v = 5'($urandom_range(15, 1));
                write_flips(v);
                src_idle_pct  <= src_tab[mode];
                sink_idle_pct <= sink_tab[mode];
                if (mode == 0 && chunk == 0) hold_start <= 1'b1;
                for (int n = 0; n < 105; n++) begin
                    if (stream_left == 0) begin
                        if (mode == 0 && chunk == 0)
                            stream_left = $urandom_range(3, 1);
                        else if ($urandom_range(7) == 0)
                            stream_left = $urandom_range(200, 25);
                        else
                            stream_left = $urandom_range(24, 1);
                        case ($urandom_range(3))
                            0: one_pct = 25;
                            1: one_pct = 50;
                            2: one_pct = 75;
                            default: one_pct = 90;
                        endcase
                    end
                    b = ($urandom_range(99) < one_pct);
                    push_bit(b, stream_left == 1, 1'b0, tw);
                    stream_left--;
                end
            end
        end
        if (stream_left != 0) push_bit(1'($urandom_range(1)), 1'b1, 1'b0, tw);

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_wins.size() != 0) @(posedge aclk);
        repeat (SettleCyc) @(posedge aclk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
